// ===== rtl/evc_pkg.sv =====
// Package for the encoder velocity classifier: field widths, fixed-point
// constants and configuration register indexes. No dependencies.
package evc_pkg;

    localparam int CountWidth  = 16;
    localparam int VelWidth    = 16;
    localparam int AccWidth    = 32;
    localparam int ThreshWidth = 16;
    localparam int CfgIdxWidth = 2;

    // Position scale is 2^ScaleShift; average is 3/8 new + 5/8 old.
    localparam int ScaleShift   = 12;
    localparam int GainNew      = 3;
    localparam int GainOld      = 5;
    localparam int GainDivShift = 3;

    localparam logic [ThreshWidth-1:0] SlowReset   = ThreshWidth'(1);
    localparam logic [ThreshWidth-1:0] MediumReset = ThreshWidth'(10);
    localparam logic [ThreshWidth-1:0] FastReset   = ThreshWidth'(100);

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_SLOW   = 2'd0,
        CFG_MEDIUM = 2'd1,
        CFG_FAST   = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        ACT_TICK  = 1'b0,
        ACT_RESET = 1'b1
    } action_t;

endpackage

// ===== rtl/encoder_velocity_classifier.sv =====
// Encoder velocity classifier top level: smoothed velocity update and
// speed/direction classification. Depends on evc_pkg.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  s_       | in        | s_valid / s_ready  | action, count_sample
//  m_       | out       | m_valid / m_ready  | velocity, direction and speed flags
//  cfg_     | in        | cfg_we             | cfg_index, cfg_wdata
//
// One item per cycle while m_ready does not stall; an item is registered in
// stage one and then in stage two before its result shows on m_. Stage one
// updates the running average and holds the 16-bit velocity; stage two holds
// the classified result. Synchronous active-low reset clears the estimator
// state and loads the default thresholds. Stalls on m_ready back up through both
// stages; s_ready drops only when both stages hold an item and m_ready is low.
module encoder_velocity_classifier (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_action,
    input  logic signed [evc_pkg::CountWidth-1:0] s_count_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [evc_pkg::VelWidth-1:0]  m_velocity,
    output logic                                 m_turning,
    output logic                                 m_clockwise,
    output logic                                 m_counter_clockwise,
    output logic                                 m_speed_slow,
    output logic                                 m_speed_medium,
    output logic                                 m_speed_fast,
    input  logic                                 cfg_we,
    input  logic [evc_pkg::CfgIdxWidth-1:0]      cfg_index,
    input  logic [evc_pkg::ThreshWidth-1:0]      cfg_wdata
);

    localparam int AccW  = evc_pkg::AccWidth;
    localparam int WideW = AccW + 3;

    // Thresholds
    logic [evc_pkg::ThreshWidth-1:0] slow_th_reg, medium_th_reg, fast_th_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slow_th_reg   <= evc_pkg::SlowReset;
            medium_th_reg <= evc_pkg::MediumReset;
            fast_th_reg   <= evc_pkg::FastReset;
        end else if (cfg_we) begin
            unique case (cfg_index)
                evc_pkg::CFG_SLOW:   slow_th_reg   <= cfg_wdata;
                evc_pkg::CFG_MEDIUM: medium_th_reg <= cfg_wdata;
                evc_pkg::CFG_FAST:   fast_th_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake between the two stages
    logic stg1_valid_reg, out_valid_reg;
    logic stg1_advance, in_accept;

    assign stg1_advance = !out_valid_reg || m_ready;
    assign s_ready      = !stg1_valid_reg || stg1_advance;
    assign in_accept    = s_valid && s_ready;

    // Estimator update
    logic signed [evc_pkg::CountWidth-1:0] prev_count_reg, prev_count_next;
    logic signed [AccW-1:0]                avg_reg, avg_next;
    logic signed [evc_pkg::CountWidth:0]   delta;
    logic signed [AccW-1:0]                delta_ext, new_term, old_term;
    logic signed [WideW-1:0]               old_x, old_adj;

    always_comb begin
        delta     = {s_count_sample[evc_pkg::CountWidth-1], s_count_sample}
                  - {prev_count_reg[evc_pkg::CountWidth-1], prev_count_reg};
        delta_ext = AccW'(delta);
        // scaled difference is a multiple of 8, so this division is exact
        new_term  = (delta_ext * AccW'(evc_pkg::GainNew))
                    <<< (evc_pkg::ScaleShift - evc_pkg::GainDivShift);
        old_x     = WideW'(avg_reg) * WideW'(evc_pkg::GainOld);
        // bias negative values so the shift truncates toward zero
        old_adj   = old_x[WideW-1]
                  ? old_x + WideW'((1 << evc_pkg::GainDivShift) - 1)
                  : old_x;
        old_term  = old_adj[evc_pkg::GainDivShift +: AccW];

        prev_count_next = prev_count_reg;
        avg_next        = avg_reg;
        if (in_accept) begin
            if (s_action == evc_pkg::ACT_RESET) begin
                prev_count_next = '0;
                avg_next        = '0;
            end else begin
                prev_count_next = s_count_sample;
                avg_next        = new_term + old_term;
            end
        end
    end

    logic signed [evc_pkg::VelWidth-1:0] stg1_vel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_count_reg <= '0;
            avg_reg        <= '0;
            stg1_valid_reg <= 1'b0;
        end else begin
            prev_count_reg <= prev_count_next;
            avg_reg        <= avg_next;
            if (s_ready) begin
                stg1_valid_reg <= in_accept;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            stg1_vel_reg <= avg_next[evc_pkg::VelWidth-1:0];
        end
    end

    // Classification
    logic [evc_pkg::VelWidth:0] mag;
    logic                       at_slow, at_medium, at_fast, cw, ccw;

    always_comb begin
        mag = stg1_vel_reg[evc_pkg::VelWidth-1]
            ? (evc_pkg::VelWidth+1)'(0) - (evc_pkg::VelWidth+1)'(stg1_vel_reg)
            : (evc_pkg::VelWidth+1)'(stg1_vel_reg);
        at_slow   = mag >= {1'b0, slow_th_reg};
        at_medium = mag >= {1'b0, medium_th_reg};
        at_fast   = mag >= {1'b0, fast_th_reg};
        ccw       = stg1_vel_reg[evc_pkg::VelWidth-1] && at_slow;
        cw        = !stg1_vel_reg[evc_pkg::VelWidth-1] && (stg1_vel_reg != '0) && at_slow;
    end

    logic signed [evc_pkg::VelWidth-1:0] m_velocity_reg;
    logic m_turning_reg, m_cw_reg, m_ccw_reg, m_slow_reg, m_medium_reg, m_fast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (stg1_advance) begin
            out_valid_reg <= stg1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stg1_advance && stg1_valid_reg) begin
            m_velocity_reg <= stg1_vel_reg;
            m_turning_reg  <= cw || ccw;
            m_cw_reg       <= cw;
            m_ccw_reg      <= ccw;
            m_slow_reg     <= at_slow && !at_medium;
            m_medium_reg   <= at_medium && !at_fast;
            m_fast_reg     <= at_fast;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_velocity          = m_velocity_reg;
    assign m_turning           = m_turning_reg;
    assign m_clockwise         = m_cw_reg;
    assign m_counter_clockwise = m_ccw_reg;
    assign m_speed_slow        = m_slow_reg;
    assign m_speed_medium      = m_medium_reg;
    assign m_speed_fast        = m_fast_reg;

endmodule

// ===== rtl/evc_checker.sv =====
// Port-level checks for the encoder velocity classifier, bound to the top
// level. Depends on evc_pkg for widths.
module evc_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [evc_pkg::VelWidth-1:0]  m_velocity,
    input logic                                 m_turning,
    input logic                                 m_clockwise,
    input logic                                 m_counter_clockwise,
    input logic                                 m_speed_medium,
    input logic                                 m_speed_fast
);

    // hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_velocity))
        else $error("stalled result changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_turning == (m_clockwise || m_counter_clockwise))
        else $error("turning flag disagrees with direction flags");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_clockwise && m_counter_clockwise))
        else $error("both directions flagged");

    // the clockwise flag must follow the sign of the velocity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clockwise |-> !m_velocity[evc_pkg::VelWidth-1] && m_velocity != '0)
        else $error("clockwise flag with non-positive velocity");

    // medium speed stops below the fast threshold
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_speed_medium && m_speed_fast))
        else $error("medium and fast speed both flagged");

endmodule

bind encoder_velocity_classifier evc_checker u_evc_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_velocity          (m_velocity),
    .m_turning           (m_turning),
    .m_clockwise         (m_clockwise),
    .m_counter_clockwise (m_counter_clockwise),
    .m_speed_medium      (m_speed_medium),
    .m_speed_fast        (m_speed_fast)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for encoder_velocity_classifier: directed and random
// tick/reset items against a built-in velocity predictor. Depends on evc_pkg.
module tb;
    import evc_pkg::*;

    typedef struct packed {
        logic signed [VelWidth-1:0] velocity;
        logic turning;
        logic clockwise;
        logic counter_clockwise;
        logic speed_slow;
        logic speed_medium;
        logic speed_fast;
    } velocity_reading_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_action = ACT_TICK;
    logic signed [CountWidth-1:0] s_count_sample = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [VelWidth-1:0] m_velocity;
    logic m_turning;
    logic m_clockwise;
    logic m_counter_clockwise;
    logic m_speed_slow;
    logic m_speed_medium;
    logic m_speed_fast;
    logic cfg_we = 1'b0;
    logic [CfgIdxWidth-1:0] cfg_index = CFG_SLOW;
    logic [ThreshWidth-1:0] cfg_wdata = '0;

    // Predictor state and its copy of the thresholds
    logic signed [CountWidth-1:0] est_prev_count = '0;
    int est_smoothed = 0;
    logic [ThreshWidth-1:0] thr_slow = SlowReset;
    logic [ThreshWidth-1:0] thr_medium = MediumReset;
    logic [ThreshWidth-1:0] thr_fast = FastReset;

    velocity_reading_t expected_readings[$];
    int mismatch_count = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int stall_left = 0;

    encoder_velocity_classifier DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_action(s_action),
        .s_count_sample(s_count_sample),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_velocity(m_velocity),
        .m_turning(m_turning),
        .m_clockwise(m_clockwise),
        .m_counter_clockwise(m_counter_clockwise),
        .m_speed_slow(m_speed_slow),
        .m_speed_medium(m_speed_medium),
        .m_speed_fast(m_speed_fast),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #2ms;
        $display("status: fail");
        $finish;
    end

    function automatic velocity_reading_t predict_velocity(action_t act,
                                                           logic signed [CountWidth-1:0] cnt);
        longint cur_pos;
        longint old_pos;
        longint avg;
        int vel_ext;
        logic signed [VelWidth-1:0] vel;
        logic [VelWidth:0] mag;
        velocity_reading_t r;
        if (act == ACT_RESET) begin
            est_prev_count = '0;
            est_smoothed = 0;
        end else begin
            cur_pos = longint'(cnt) * (1 << ScaleShift);
            old_pos = longint'(est_prev_count) * (1 << ScaleShift);
            // longint division truncates toward zero
            avg = (GainNew * (cur_pos - old_pos)) / (1 << GainDivShift)
                + (GainOld * longint'(est_smoothed)) / (1 << GainDivShift);
            est_smoothed = int'(avg);
            est_prev_count = cnt;
        end
        vel = est_smoothed[VelWidth-1:0];
        vel_ext = vel;
        mag = (vel_ext < 0) ? 17'(-vel_ext) : 17'(vel_ext);
        r.velocity = vel;
        r.clockwise = (vel_ext > 0) && (mag >= {1'b0, thr_slow});
        r.counter_clockwise = (vel_ext < 0) && (mag >= {1'b0, thr_slow});
        r.turning = r.clockwise || r.counter_clockwise;
        r.speed_slow = (mag >= {1'b0, thr_slow}) && (mag < {1'b0, thr_medium});
        r.speed_medium = (mag >= {1'b0, thr_medium}) && (mag < {1'b0, thr_fast});
        r.speed_fast = (mag >= {1'b0, thr_fast});
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Random receiver stalls in bursts, each started with a chance of stall_pct percent
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(0, 7);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Sample between edges; the item moves at the next rising edge
    always @(negedge aclk) begin : check_readings
        velocity_reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_readings.size() == 0) begin
                report_mismatch("unexpected item", int'(m_velocity), 0);
            end else begin
                want = expected_readings.pop_front();
                if (m_velocity !== want.velocity)
                    report_mismatch("velocity", int'(m_velocity), int'(want.velocity));
                if (m_turning !== want.turning)
                    report_mismatch("turning", m_turning, want.turning);
                if (m_clockwise !== want.clockwise)
                    report_mismatch("clockwise", m_clockwise, want.clockwise);
                if (m_counter_clockwise !== want.counter_clockwise)
                    report_mismatch("counter_clockwise", m_counter_clockwise,
                                    want.counter_clockwise);
                if (m_speed_slow !== want.speed_slow)
                    report_mismatch("speed_slow", m_speed_slow, want.speed_slow);
                if (m_speed_medium !== want.speed_medium)
                    report_mismatch("speed_medium", m_speed_medium, want.speed_medium);
                if (m_speed_fast !== want.speed_fast)
                    report_mismatch("speed_fast", m_speed_fast, want.speed_fast);
            end
        end
    end

    // Call at a rising edge; returns at the edge that accepts the item
    task automatic send_item(action_t act, logic signed [CountWidth-1:0] cnt);
        if ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_count_sample <= cnt;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        expected_readings.push_back(predict_velocity(act, cnt));
        @(posedge aclk);
    endtask

    task automatic wait_for_readings();
        s_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all three thresholds on consecutive cycles; block must be idle
    task automatic write_thresholds(logic [ThreshWidth-1:0] slow,
                                    logic [ThreshWidth-1:0] mid,
                                    logic [ThreshWidth-1:0] fast);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SLOW;
        cfg_wdata <= slow;
        @(posedge aclk);
        cfg_index <= CFG_MEDIUM;
        cfg_wdata <= mid;
        @(posedge aclk);
        cfg_index <= CFG_FAST;
        cfg_wdata <= fast;
        @(posedge aclk);
        cfg_we <= 1'b0;
        thr_slow = slow;
        thr_medium = mid;
        thr_fast = fast;
    endtask

    task automatic test_reset_item();
        gap_pct = 30;
        stall_pct = 30;
        send_item(ACT_RESET, 16'sh7FFF);
        send_item(ACT_TICK, 16'sd0);
        send_item(ACT_TICK, 16'sd1);
        send_item(ACT_RESET, -16'sd1);
    endtask

    task automatic test_count_extremes();
        send_item(ACT_TICK, 16'sh7FFF);
        send_item(ACT_TICK, -16'sh8000);
        send_item(ACT_TICK, 16'sh7FFF);
        send_item(ACT_TICK, -16'sh8000);
        send_item(ACT_TICK, -16'sd1);
        send_item(ACT_TICK, 16'sd0);
        send_item(ACT_TICK, 16'sd1);
    endtask

    // From a cleared estimator, a tick of +/-64 lands the velocity on -32768
    task automatic test_most_negative_velocity();
        wait_for_readings();
        write_thresholds(16'd1, 16'd32768, 16'd32769);
        send_item(ACT_RESET, 16'sd0);
        send_item(ACT_TICK, 16'sd64);
        send_item(ACT_RESET, 16'sd0);
        send_item(ACT_TICK, -16'sd64);
        wait_for_readings();
        write_thresholds(16'd32769, 16'd0, 16'd32768);
        send_item(ACT_RESET, 16'sd0);
        send_item(ACT_TICK, 16'sd64);
    endtask

    task automatic test_threshold_extremes();
        wait_for_readings();
        write_thresholds(16'd0, 16'd0, 16'd0);
        send_item(ACT_RESET, 16'sd0);
        send_item(ACT_TICK, 16'sd5);
        wait_for_readings();
        write_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(ACT_TICK, 16'sd20);
        wait_for_readings();
        // unordered thresholds: each speed flag is its own comparison masked by the next higher one
        write_thresholds(16'd100, 16'd10, 16'd1);
        send_item(ACT_TICK, 16'sd3);
        send_item(ACT_TICK, 16'sd3);
    endtask

    task automatic test_random_traffic();
        int phase;
        int n;
        int pick;
        int mid;
        int fast;
        logic signed [CountWidth-1:0] walk_pos;
        walk_pos = '0;
        for (phase = 0; phase < 5; phase++) begin
            wait_for_readings();
            if (phase == 0) begin
                write_thresholds(SlowReset, MediumReset, FastReset);
            end else if (phase == 2) begin
                write_thresholds(16'($urandom), 16'($urandom), 16'($urandom));
            end else begin
                mid = 0;
                fast = 0;
                pick = $urandom_range(0, 2000);
                mid = pick + $urandom_range(0, 8000);
                fast = mid + $urandom_range(0, 30000);
                write_thresholds(16'(pick), 16'(mid), 16'(fast));
            end
            for (n = 0; n < 150; n++) begin
                if (phase == 4) begin
                    gap_pct = 0;
                    stall_pct = 0;
                end else if (n % 25 == 0) begin
                    gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
                    stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
                end
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    send_item(ACT_RESET, 16'($urandom));
                    walk_pos = '0;
                end else if (pick < 13) begin
                    walk_pos = 16'($urandom);
                    send_item(ACT_TICK, walk_pos);
                end else begin
                    // mostly a slow walk so the smoothed velocity settles
                    walk_pos = walk_pos + 16'($signed($urandom_range(0, 32)) - 16);
                    send_item(ACT_TICK, walk_pos);
                end
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        test_reset_item();
        test_count_extremes();
        test_most_negative_velocity();
        test_threshold_extremes();
        test_random_traffic();
        wait_for_readings();
        if (mismatch_count == 0 && expected_readings.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
